### hdl/dntcd_pkg.sv
// types, constants and microcode table for the day number to calendar date block
package dntcd_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned REM_W    = 17;
  localparam int unsigned PC_W     = 5;
  localparam int unsigned OUT_W    = 56;
  localparam logic [REM_W-1:0] DAY_SECONDS = 17'd86400;
  localparam logic [YEAR_W-1:0] CYCLE_LAST = 14'd399;

  localparam logic [8:0] MONTH_END [12] = '{
    9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  typedef enum logic [2:0] {
    OP_MUL,
    OP_YRED,
    OP_YEAR,
    OP_MONTH,
    OP_HDIV,
    OP_MDIV,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [REM_W-1:0] konst;
  } ucw_t;

  localparam logic [PC_W-1:0] PC_LAST = 5'd20;

  // program: time product, year mod 400, year walk, month walk, hour and minute digits
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w.op    = OP_DONE;
    w.konst = '0;
    unique case (pc)
      5'd0:  begin w.op = OP_MUL;   w.konst = 17'd0;     end
      5'd1:  begin w.op = OP_YRED;  w.konst = 17'd12800; end
      5'd2:  begin w.op = OP_YRED;  w.konst = 17'd6400;  end
      5'd3:  begin w.op = OP_YRED;  w.konst = 17'd3200;  end
      5'd4:  begin w.op = OP_YRED;  w.konst = 17'd1600;  end
      5'd5:  begin w.op = OP_YRED;  w.konst = 17'd800;   end
      5'd6:  begin w.op = OP_YRED;  w.konst = 17'd400;   end
      5'd7:  begin w.op = OP_YEAR;  w.konst = 17'd0;     end
      5'd8:  begin w.op = OP_MONTH; w.konst = 17'd0;     end
      5'd9:  begin w.op = OP_HDIV;  w.konst = 17'd57600; end
      5'd10: begin w.op = OP_HDIV;  w.konst = 17'd28800; end
      5'd11: begin w.op = OP_HDIV;  w.konst = 17'd14400; end
      5'd12: begin w.op = OP_HDIV;  w.konst = 17'd7200;  end
      5'd13: begin w.op = OP_HDIV;  w.konst = 17'd3600;  end
      5'd14: begin w.op = OP_MDIV;  w.konst = 17'd1920;  end
      5'd15: begin w.op = OP_MDIV;  w.konst = 17'd960;   end
      5'd16: begin w.op = OP_MDIV;  w.konst = 17'd480;   end
      5'd17: begin w.op = OP_MDIV;  w.konst = 17'd240;   end
      5'd18: begin w.op = OP_MDIV;  w.konst = 17'd120;   end
      5'd19: begin w.op = OP_MDIV;  w.konst = 17'd60;    end
      default: begin w.op = OP_DONE; w.konst = 17'd0;    end
    endcase
    return w;
  endfunction

  // leap from year mod 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] r);
    return (r[1:0] == 2'd0) && (r != 14'd100) && (r != 14'd200) && (r != 14'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [8:0] prev;
    logic [8:0] len;
    prev = (m == 4'd0) ? 9'd0 : MONTH_END[m - 4'd1];
    len  = MONTH_END[m] - prev + {8'd0, leap && (m == 4'd1)};
    return len[4:0];
  endfunction

endpackage

### hdl/day_number_to_calendar_date.sv
// day number to calendar date and time of day, microcoded sequencer
// run time grows with the years stepped and with the month index (0..11), as the year walk
// steps one year per cycle
// throughput: one item at a time; the next item is taken once the result is in the output
// register, so it overlaps a result still waiting downstream
// reset: rst synchronous active high clears the sequencer and output valid; no table clearing
module day_number_to_calendar_date #(
  parameter int unsigned DAY_COUNT_BITS = 15
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_year[13:0], day_count[DAY_COUNT_BITS-1:0], day_fraction[31:0], zero pad
  input  logic [((dntcd_pkg::YEAR_W + DAY_COUNT_BITS + dntcd_pkg::FRAC_W + 7) / 8) * 8 - 1:0]
               s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // year[13:0], month[3:0], day[4:0], hour[4:0], minute[5:0], second[5:0], sub_second[15:0]
  output logic [dntcd_pkg::OUT_W-1:0] m_tdata
);

  localparam int unsigned DCB     = DAY_COUNT_BITS;
  localparam int unsigned YW      = dntcd_pkg::YEAR_W;
  localparam int unsigned FW      = dntcd_pkg::FRAC_W;
  localparam int unsigned RW      = dntcd_pkg::REM_W;
  localparam int unsigned PROD_W  = FW + RW;

  logic                        busy;
  logic [dntcd_pkg::PC_W-1:0]  pc;
  dntcd_pkg::ucw_t             uw;

  logic [YW-1:0]   yr;
  logic [YW-1:0]   r400;
  logic [DCB-1:0]  n;
  logic [3:0]      mon;
  logic [FW-1:0]   frac;
  logic [RW-1:0]   rem;
  logic [15:0]     sub;
  logic [4:0]      hour;
  logic [5:0]      minute;

  logic [DCB-1:0]  day_in;
  logic [PROD_W-1:0] prod;
  logic [RW-1:0]   sub_a;
  logic [RW-1:0]   diff;
  logic            ge;
  logic            leap;
  logic [8:0]      ylen;
  logic [4:0]      mlen;
  logic            year_go;
  logic            mon_go;
  logic            out_full;
  logic            stay;
  logic            done_fire;
  logic            accept;

  assign uw       = dntcd_pkg::ucode(pc);
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign day_in   = s_tdata[YW +: DCB];

  assign prod  = PROD_W'(frac) * PROD_W'(dntcd_pkg::DAY_SECONDS);

  // shared compare and subtract for year mod 400 and the hour and minute digits
  assign sub_a = (uw.op == dntcd_pkg::OP_YRED) ? RW'(r400) : rem;
  assign ge    = sub_a >= uw.konst;
  assign diff  = sub_a - uw.konst;

  assign leap    = dntcd_pkg::is_leap(r400);
  assign ylen    = leap ? 9'd366 : 9'd365;
  assign mlen    = dntcd_pkg::month_len(mon, leap);
  assign year_go = n > DCB'(ylen);
  assign mon_go  = (mon < 4'd11) && (n > DCB'(mlen));

  assign out_full  = m_tvalid && !m_tready;
  assign stay      = ((uw.op == dntcd_pkg::OP_YEAR) && year_go) ||
                     ((uw.op == dntcd_pkg::OP_MONTH) && mon_go) ||
                     ((uw.op == dntcd_pkg::OP_DONE) && out_full);
  assign done_fire = busy && (uw.op == dntcd_pkg::OP_DONE) && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pc       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        pc   <= '0;
      end else if (busy) begin
        if (done_fire) begin
          busy <= 1'b0;
        end else if (!stay) begin
          pc <= pc + 5'd1;
        end
      end
      if (done_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      yr   <= s_tdata[YW-1:0];
      r400 <= s_tdata[YW-1:0];
      n    <= (day_in == '0) ? DCB'(1) : day_in;
      frac <= s_tdata[YW + DCB +: FW];
      mon  <= 4'd0;
    end else if (busy) begin
      unique case (uw.op)
        dntcd_pkg::OP_MUL: begin
          rem <= prod[PROD_W-1:FW];
          sub <= prod[FW-1:FW-16];
        end
        dntcd_pkg::OP_YRED: begin
          if (ge) begin
            r400 <= diff[YW-1:0];
          end
        end
        dntcd_pkg::OP_YEAR: begin
          if (year_go) begin
            n    <= n - DCB'(ylen);
            yr   <= yr + 14'd1;
            r400 <= (r400 == dntcd_pkg::CYCLE_LAST) ? '0 : r400 + 14'd1;
          end
        end
        dntcd_pkg::OP_MONTH: begin
          if (mon_go) begin
            n   <= n - DCB'(mlen);
            mon <= mon + 4'd1;
          end
        end
        dntcd_pkg::OP_HDIV: begin
          hour <= {hour[3:0], ge};
          if (ge) begin
            rem <= diff;
          end
        end
        dntcd_pkg::OP_MDIV: begin
          minute <= {minute[4:0], ge};
          if (ge) begin
            rem <= diff;
          end
        end
        dntcd_pkg::OP_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      m_tdata <= {sub, rem[5:0], minute, hour, n[4:0], mon + 4'd1, yr};
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (busy && (pc == '0)))
    else $error("sequencer did not start at step zero");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc <= dntcd_pkg::PC_LAST))
    else $error("step counter ran past the program");

  a_cycle_res: assert property (@(posedge clk) disable iff (rst)
    (busy && (uw.op == dntcd_pkg::OP_YEAR)) |-> (r400 <= dntcd_pkg::CYCLE_LAST))
    else $error("year residue out of range in year walk");

  a_month: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= 4'd12) &&
                  (m_tdata[22:18] != 5'd0)))
    else $error("month or day out of range");

endmodule
